[design/mrd_pkg.sv]
package mrd_pkg;

  localparam int unsigned HEADER_BYTES     = 16;
  localparam int unsigned TRAILER_BYTES_DEF = 16;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRL_EN  = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_TRAILER = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    EV_HDR_BYTE = 3'd0,
    EV_HDR_OK   = 3'd1,
    EV_PAYLOAD  = 3'd2,
    EV_TRAILER  = 3'd3,
    EV_CLEAN    = 3'd4,
    EV_ERROR    = 3'd5,
    EV_IDLE     = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_MAGIC = 2'd1,
    ERR_LONG  = 2'd2,
    ERR_SHORT = 2'd3
  } err_e;

  typedef enum logic {
    TOK_BYTE = 1'b0,
    TOK_EOS  = 1'b1
  } tok_e;

  typedef struct packed {
    tok_e       kind;
    logic [7:0] data;
  } token_t;

  typedef struct packed {
    logic [31:0] magic;
    logic [31:0] max_len;
    logic        trl_en;
  } cfg_t;

  typedef struct packed {
    event_e      ev;
    logic [7:0]  data;
    logic        done;
    logic [31:0] length;
    logic [31:0] auth;
    logic [31:0] rcode;
    err_e        err;
    logic        zeroed;
  } result_t;

endpackage

[design/mrd_front.sv]
module mrd_front import mrd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       mode_i,
  input  logic [7:0] rx_byte_i,
  output logic       tok_valid_o,
  output token_t     tok_o,
  input  logic       tok_pop_i
);

  // two-entry queue of classified requests
  token_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;
  token_t     tok_in;

  assign full        = (cnt_q == 2'd2);
  assign tok_valid_o = (cnt_q != 2'd0);
  assign tok_o       = mem_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = tok_pop_i && tok_valid_o;

  always_comb begin
    tok_in.kind = mode_i ? TOK_EOS : TOK_BYTE;
    tok_in.data = mode_i ? 8'd0 : rx_byte_i;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= tok_in;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("accepted request not counted");

endmodule

[design/mrd_back.sv]
module mrd_back import mrd_pkg::*; #(
  parameter int unsigned TRAILER_BYTES = TRAILER_BYTES_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    tok_valid_i,
  input  token_t  tok_i,
  output logic    tok_pop_o,
  output logic    res_valid_o,
  output result_t res_o,
  input  logic    res_pop_i
);

  localparam int unsigned TCW = $clog2(TRAILER_BYTES + 1);
  localparam logic [TCW-1:0] TRL_LAST = TCW'(TRAILER_BYTES - 1);

  phase_e      phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d;
  logic [TCW-1:0] trl_q, trl_d;
  logic [31:0] words_q [4];
  logic [31:0] words_d [4];
  logic [31:0] len_q, len_d;
  err_e        err_q, err_d;

  logic        out_valid_q;
  result_t     res_q, res_d;
  logic        take;
  logic [1:0]  widx;
  logic [31:0] cnt_inc;
  logic        hdr_last, magic_bad, too_long, pay_last, trl_last;

  assign take      = tok_valid_i && (!out_valid_q || res_pop_i);
  assign tok_pop_o = take;
  assign res_valid_o = out_valid_q;
  assign res_o     = res_q;

  assign widx      = cnt_q[3:2];
  assign cnt_inc   = cnt_q + 32'd1;
  assign hdr_last  = (cnt_q == 32'(HEADER_BYTES - 1));
  assign magic_bad = (words_q[0] != cfg_i.magic);
  assign too_long  = (cfg_i.max_len != 32'd0) && (words_q[1] > cfg_i.max_len);
  assign pay_last  = (cnt_inc >= len_q);
  assign trl_last  = (trl_q == TRL_LAST);

  // next state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    trl_d   = trl_q;
    words_d = words_q;
    len_d   = len_q;
    err_d   = err_q;
    if (take && err_q == ERR_NONE) begin
      if (tok_i.kind == TOK_EOS) begin
        if (phase_q == PH_HEADER && cnt_q == 32'd0) begin
          phase_d = PH_HEADER;
        end else if (phase_q == PH_TRAILER && trl_q == '0) begin
          phase_d = PH_HEADER;
        end else begin
          err_d = ERR_SHORT;
        end
      end else begin
        case (phase_q)
          PH_HEADER: begin
            words_d[widx] = {words_q[widx][23:0], tok_i.data};
            cnt_d = cnt_inc;
            if (hdr_last) begin
              if (magic_bad) begin
                err_d = ERR_MAGIC;
              end else if (too_long) begin
                err_d = ERR_LONG;
              end else begin
                len_d = words_q[1];
                cnt_d = 32'd0;
                trl_d = '0;
                if (words_q[1] != 32'd0) begin
                  phase_d = PH_PAYLOAD;
                end else begin
                  phase_d = cfg_i.trl_en ? PH_TRAILER : PH_HEADER;
                end
              end
            end
          end
          PH_PAYLOAD: begin
            cnt_d = cnt_inc;
            if (pay_last) begin
              cnt_d   = 32'd0;
              trl_d   = '0;
              phase_d = cfg_i.trl_en ? PH_TRAILER : PH_HEADER;
            end
          end
          PH_TRAILER: begin
            if (trl_last) begin
              trl_d   = '0;
              phase_d = PH_HEADER;
            end else begin
              trl_d = trl_q + TCW'(1);
            end
          end
          default: begin
            phase_d = PH_HEADER;
          end
        endcase
      end
    end
  end

  // result for the request being taken
  always_comb begin
    res_d        = '0;
    res_d.ev     = EV_HDR_BYTE;
    res_d.err    = ERR_NONE;
    if (err_q != ERR_NONE) begin
      res_d.ev  = EV_IDLE;
      res_d.err = err_q;
    end else if (tok_i.kind == TOK_EOS) begin
      if (phase_q == PH_HEADER && cnt_q == 32'd0) begin
        res_d.ev = EV_CLEAN;
      end else if (phase_q == PH_TRAILER && trl_q == '0) begin
        // end of stream stands in for the whole trailer
        res_d.ev     = EV_TRAILER;
        res_d.done   = 1'b1;
        res_d.zeroed = 1'b1;
        res_d.length = len_q;
        res_d.auth   = words_q[2];
        res_d.rcode  = words_q[3];
      end else begin
        res_d.ev  = EV_ERROR;
        res_d.err = ERR_SHORT;
      end
    end else begin
      case (phase_q)
        PH_HEADER: begin
          if (hdr_last) begin
            if (magic_bad) begin
              res_d.ev  = EV_ERROR;
              res_d.err = ERR_MAGIC;
            end else if (too_long) begin
              res_d.ev  = EV_ERROR;
              res_d.err = ERR_LONG;
            end else begin
              res_d.ev     = EV_HDR_OK;
              res_d.done   = (words_q[1] == 32'd0) && !cfg_i.trl_en;
              res_d.length = words_q[1];
              res_d.auth   = words_q[2];
              // the last header byte completes the result word
              res_d.rcode  = {words_q[3][23:0], tok_i.data};
            end
          end
        end
        PH_PAYLOAD: begin
          res_d.ev     = EV_PAYLOAD;
          res_d.data   = tok_i.data;
          res_d.done   = pay_last && !cfg_i.trl_en;
          res_d.length = len_q;
          res_d.auth   = words_q[2];
          res_d.rcode  = words_q[3];
        end
        PH_TRAILER: begin
          res_d.ev     = EV_TRAILER;
          res_d.data   = tok_i.data;
          res_d.done   = trl_last;
          res_d.length = len_q;
          res_d.auth   = words_q[2];
          res_d.rcode  = words_q[3];
        end
        default: begin
          res_d.ev = EV_HDR_BYTE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      cnt_q       <= 32'd0;
      trl_q       <= '0;
      words_q     <= '{default: 32'd0};
      len_q       <= 32'd0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      trl_q       <= trl_d;
      words_q     <= words_d;
      len_q       <= len_d;
      err_q       <= err_d;
      out_valid_q <= take || (out_valid_q && !res_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ERR_NONE) |=> (err_q == $past(err_q)))
    else $error("sticky error changed");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_pop_i) |=> (out_valid_q && $stable(res_q)))
    else $error("waiting result lost");
  a_trl_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (trl_q != '0) |-> (phase_q == PH_TRAILER))
    else $error("trailer count outside trailer phase");
  a_cnt_trailer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_TRAILER) |-> (cnt_q == 32'd0))
    else $error("section count not cleared for trailer");

endmodule

[design/message_receive_deframer.sv]
// Receive-side message deframer.
// Input queue: one request per push, mode_i = 0 carries rx_byte_i, mode_i = 1
// marks end of stream. A request is taken on a clock edge with push high and
// full low. Result queue: while empty is low the oldest result sits on the
// result ports; it is taken on an edge with pop high. Every request yields
// exactly one result.
// Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 magic value,
// 1 max length, 2 trailer enable); the user must write only while no request is
// in flight, which the block itself does not enforce.
// Throughput: 1 request per cycle while pop keeps up, with one header/payload/
// trailer step per request in the back end; a 2-entry request queue lets push
// run while the back end waits for result space.
// When pop stalls, the result register holds; the back end stops and the
// request queue fills, then full rises.
// Reset: config registers clear, the deframer returns to the header phase,
// the sticky error clears and both queues empty.
module message_receive_deframer import mrd_pkg::*; #(
  parameter int unsigned TRAILER_BYTES = TRAILER_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic                  mode_i,
  input  logic [7:0]            rx_byte_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [2:0]            event_res_o,
  output logic [7:0]            data_byte_o,
  output logic                  message_done_o,
  output logic [31:0]           payload_length_o,
  output logic [31:0]           auth_kind_o,
  output logic [31:0]           result_code_o,
  output logic [1:0]            error_code_o,
  output logic                  trailer_zeroed_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t    cfg_q;
  logic    tok_valid, tok_pop, res_valid;
  token_t  tok;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAGIC:   cfg_q.magic   <= cfg_wdata_i;
        CFG_MAX_LEN: cfg_q.max_len <= cfg_wdata_i;
        CFG_TRL_EN:  cfg_q.trl_en  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  mrd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .mode_i      (mode_i),
    .rx_byte_i   (rx_byte_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_pop_i   (tok_pop)
  );

  mrd_back #(
    .TRAILER_BYTES (TRAILER_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_pop_o   (tok_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  assign empty            = !res_valid;
  assign event_res_o      = res.ev;
  assign data_byte_o      = res.data;
  assign message_done_o   = res.done;
  assign payload_length_o = res.length;
  assign auth_kind_o      = res.auth;
  assign result_code_o    = res.rcode;
  assign error_code_o     = res.err;
  assign trailer_zeroed_o = res.zeroed;

endmodule

[bench/testbench.sv]
module testbench;
  import mrd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TRL_BYTES   = TRAILER_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic                  mode_i;
  logic [7:0]            rx_byte_i;
  logic                  empty;
  logic                  pop;
  logic [2:0]            event_res_o;
  logic [7:0]            data_byte_o;
  logic                  message_done_o;
  logic [31:0]           payload_length_o;
  logic [31:0]           auth_kind_o;
  logic [31:0]           result_code_o;
  logic [1:0]            error_code_o;
  logic                  trailer_zeroed_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  message_receive_deframer #(.TRAILER_BYTES(TRL_BYTES)) uut (.*);

  // register copies
  logic [31:0] cfg_magic;
  logic [31:0] cfg_max;
  logic        cfg_trl;

  // deframer state copy
  phase_e      frame_phase;
  logic [31:0] section_cnt;
  logic [31:0] hdr_words [4];
  logic [31:0] msg_length;
  err_e        sticky_err;

  result_t     expected_results [$];
  int          mismatch_count = 0;
  int          sent_count     = 0;
  int          cycle_count    = 0;
  int          send_idle      = 0;
  int          recv_idle      = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= recv_idle);
  end

  function automatic result_t frame_result(event_e ev, logic [7:0] b, logic done,
                                           err_e err, logic zeroed);
    result_t r;
    logic    hdr;
    hdr      = (ev == EV_HDR_OK) || (ev == EV_PAYLOAD) || (ev == EV_TRAILER);
    r.ev     = ev;
    r.data   = b;
    r.done   = done;
    r.length = hdr ? msg_length   : 32'h0;
    r.auth   = hdr ? hdr_words[2] : 32'h0;
    r.rcode  = hdr ? hdr_words[3] : 32'h0;
    r.err    = err;
    r.zeroed = zeroed;
    return r;
  endfunction

  // payload finished: go to trailer, or close the message right away
  function automatic logic end_of_payload();
    section_cnt = 32'h0;
    if (cfg_trl) begin
      frame_phase = PH_TRAILER;
      return 1'b0;
    end
    frame_phase = PH_HEADER;
    return 1'b1;
  endfunction

  task automatic deframe_predict(input tok_e kind, input logic [7:0] b, output result_t r);
    int unsigned idx;
    logic        done;
    if (sticky_err != ERR_NONE) begin
      r = frame_result(EV_IDLE, 8'h00, 1'b0, sticky_err, 1'b0);
    end else if (kind == TOK_EOS) begin
      if (frame_phase == PH_HEADER && section_cnt == 0) begin
        r = frame_result(EV_CLEAN, 8'h00, 1'b0, ERR_NONE, 1'b0);
      end else if (frame_phase == PH_TRAILER && section_cnt == 0) begin
        r = frame_result(EV_TRAILER, 8'h00, 1'b1, ERR_NONE, 1'b1);
        frame_phase = PH_HEADER;
      end else begin
        sticky_err = ERR_SHORT;
        r = frame_result(EV_ERROR, 8'h00, 1'b0, ERR_SHORT, 1'b0);
      end
    end else if (frame_phase == PH_HEADER) begin
      idx = (section_cnt >> 2) & 3;
      hdr_words[idx] = {hdr_words[idx][23:0], b};
      section_cnt++;
      if (section_cnt < HEADER_BYTES) begin
        r = frame_result(EV_HDR_BYTE, 8'h00, 1'b0, ERR_NONE, 1'b0);
      end else if (hdr_words[0] != cfg_magic) begin
        sticky_err = ERR_MAGIC;
        r = frame_result(EV_ERROR, 8'h00, 1'b0, ERR_MAGIC, 1'b0);
      end else if (cfg_max != 0 && hdr_words[1] > cfg_max) begin
        sticky_err = ERR_LONG;
        r = frame_result(EV_ERROR, 8'h00, 1'b0, ERR_LONG, 1'b0);
      end else begin
        msg_length  = hdr_words[1];
        section_cnt = 32'h0;
        done        = 1'b0;
        if (msg_length == 0) done = end_of_payload();
        else frame_phase = PH_PAYLOAD;
        r = frame_result(EV_HDR_OK, 8'h00, done, ERR_NONE, 1'b0);
      end
    end else if (frame_phase == PH_PAYLOAD) begin
      section_cnt++;
      done = 1'b0;
      if (section_cnt >= msg_length) done = end_of_payload();
      r = frame_result(EV_PAYLOAD, b, done, ERR_NONE, 1'b0);
    end else begin
      section_cnt++;
      if (section_cnt >= TRL_BYTES) begin
        r = frame_result(EV_TRAILER, b, 1'b1, ERR_NONE, 1'b0);
        frame_phase = PH_HEADER;
        section_cnt = 32'h0;
      end else begin
        r = frame_result(EV_TRAILER, b, 1'b0, ERR_NONE, 1'b0);
      end
    end
  endtask

  task automatic send_request(input tok_e kind, input logic [7:0] b);
    logic    taken;
    result_t r;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    mode_i    <= kind;
    rx_byte_i <= b;
    taken = 1'b0;
    // sample full mid-cycle, where every input and output is settled
    while (!taken) begin
      @(negedge clk_i);
      taken = !full;
      @(posedge clk_i);
    end
    deframe_predict(kind, b, r);
    expected_results.push_back(r);
    sent_count++;
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_MAGIC:   cfg_magic = data;
      CFG_MAX_LEN: cfg_max   = data;
      CFG_TRL_EN:  cfg_trl   = data[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] magic, input logic [31:0] max_len,
                           input logic trl);
    wait_idle();
    write_register(CFG_MAGIC, magic);
    write_register(CFG_MAX_LEN, max_len);
    write_register(CFG_TRL_EN, {31'h0, trl});
  endtask

  // header bytes go out big-endian, magic word first; n_bytes < 16 cuts it short
  task automatic send_header(input logic [31:0] magic, input logic [31:0] len,
                             input logic [31:0] auth, input logic [31:0] rcode,
                             input int n_bytes = HEADER_BYTES);
    logic [127:0] words;
    int           i;
    words = {magic, len, auth, rcode};
    for (i = 0; i < n_bytes; i++) send_request(TOK_BYTE, words[127-8*i -: 8]);
  endtask

  task automatic send_frame(input logic [31:0] len);
    int i;
    send_header(cfg_magic, len, $urandom, $urandom);
    for (i = 0; i < len; i++) send_request(TOK_BYTE, 8'($urandom));
    if (cfg_trl) begin
      if ($urandom_range(3) == 0) begin
        send_request(TOK_EOS, 8'($urandom));
      end else begin
        for (i = 0; i < TRL_BYTES; i++) send_request(TOK_BYTE, 8'($urandom));
      end
    end
  endtask

  task automatic test_basic_frame();
    configure(32'hFFFF_FFFF, 32'h1, 1'b0);
    // length equal to the limit is still accepted
    send_header(32'hFFFF_FFFF, 32'h1, 32'h0, 32'hFFFF_FFFF);
    send_request(TOK_BYTE, 8'hFF);
    send_request(TOK_EOS, 8'h00);
  endtask

  task automatic test_simulated_trailer();
    configure(32'h0, 32'h0, 1'b1);
    // zero-length payload goes straight to the trailer, end of stream fills it
    send_header(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_request(TOK_EOS, 8'hFF);
    send_request(TOK_EOS, 8'h5A);
  endtask

  task automatic test_config_mid_message();
    configure($urandom, 32'h0, 1'b0);
    send_header(cfg_magic, 32'h2, $urandom, $urandom);
    send_request(TOK_BYTE, 8'h00);
    wait_idle();
    // trailer enable is read only when the payload ends
    write_register(CFG_TRL_EN, 32'h1);
    send_request(TOK_BYTE, 8'hA5);
    send_request(TOK_EOS, 8'h00);
  endtask

  task automatic test_random_frames(input int s_idle, input int r_idle, input int goal);
    int          start;
    logic [31:0] magic;
    logic [31:0] max_len;
    logic [31:0] len;
    send_idle = s_idle;
    recv_idle = r_idle;
    start     = sent_count;
    while (sent_count - start < goal) begin
      if (sent_count == start || $urandom_range(7) == 0) begin
        case ($urandom_range(2))
          0:       magic = 32'h0;
          1:       magic = 32'hFFFF_FFFF;
          default: magic = $urandom;
        endcase
        case ($urandom_range(3))
          0:       max_len = 32'h0;
          1:       max_len = 32'hFFFF_FFFF;
          default: max_len = $urandom_range(1, 30);
        endcase
        configure(magic, max_len, 1'($urandom_range(1)));
      end
      if (cfg_max != 0 && cfg_max <= 64) begin
        len = ($urandom_range(2) == 0) ? cfg_max : $urandom_range(0, cfg_max);
      end else if ($urandom_range(15) == 0) begin
        len = 64;
      end else begin
        len = $urandom_range(0, 20);
      end
      send_frame(len);
      if ($urandom_range(4) == 0) send_request(TOK_EOS, 8'($urandom));
    end
  endtask

  // errors stick until reset, so only one kind can be hit per run
  task automatic test_sticky_error();
    err_e kind;
    int   i;
    kind = err_e'($urandom_range(1, 3));
    case (kind)
      ERR_MAGIC: begin
        configure($urandom, 32'h0, 1'($urandom_range(1)));
        send_header(cfg_magic ^ (32'h1 << $urandom_range(31)), 32'h4, $urandom, $urandom);
      end
      ERR_LONG: begin
        configure($urandom, $urandom_range(1, 30), 1'($urandom_range(1)));
        send_header(cfg_magic, cfg_max + 1 + $urandom_range(0, 1000), $urandom, $urandom);
      end
      default: begin
        configure($urandom, 32'h0, 1'($urandom_range(1)));
        if ($urandom_range(1)) begin
          send_header(cfg_magic, 32'h3, $urandom, $urandom, $urandom_range(1, 15));
        end else begin
          send_header(cfg_magic, 32'h3, $urandom, $urandom);
          for (i = 0; i < $urandom_range(0, 2); i++) send_request(TOK_BYTE, 8'($urandom));
        end
        send_request(TOK_EOS, 8'($urandom));
      end
    endcase
    for (i = 0; i < 40; i++) send_request(tok_e'($urandom_range(1)), 8'($urandom));
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  initial begin : result_checker
    result_t exp_r;
    forever begin
      @(negedge clk_i);
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result with no request waiting: event_res 0x%0h", event_res_o);
          mismatch_count++;
        end else begin
          exp_r = expected_results.pop_front();
          compare_field("event_res", exp_r.ev, event_res_o);
          compare_field("data_byte", exp_r.data, data_byte_o);
          compare_field("message_done", exp_r.done, message_done_o);
          compare_field("payload_length", exp_r.length, payload_length_o);
          compare_field("auth_kind", exp_r.auth, auth_kind_o);
          compare_field("result_code", exp_r.rcode, result_code_o);
          compare_field("error_code", exp_r.err, error_code_o);
          compare_field("trailer_zeroed", exp_r.zeroed, trailer_zeroed_o);
        end
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    push        = 1'b0;
    mode_i      = 1'b0;
    rx_byte_i   = 8'h00;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_MAGIC;
    cfg_wdata_i = 32'h0;
    cfg_magic   = 32'h0;
    cfg_max     = 32'h0;
    cfg_trl     = 1'b0;
    frame_phase = PH_HEADER;
    section_cnt = 32'h0;
    msg_length  = 32'h0;
    sticky_err  = ERR_NONE;
    foreach (hdr_words[i]) hdr_words[i] = 32'h0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 30;
    recv_idle = 79;
    test_basic_frame();
    test_simulated_trailer();
    test_config_mid_message();
    test_random_frames(30, 79, 530);
    test_random_frames(79, 30, 530);
    test_random_frames(0, 0, 530);
    test_sticky_error();

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
